[src/matrix_keypad_scanner_core_macros.svh]
// ----------------------------------------------------------------------------
// Keypad scanner assertion macros
// Shared concurrent assertion forms for the keypad scanner checkers.
// ----------------------------------------------------------------------------
`ifndef MATRIX_KEYPAD_SCANNER_CORE_MACROS_SVH
`define MATRIX_KEYPAD_SCANNER_CORE_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while reset is asserted.
`define MKS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while reset is asserted.
`define MKS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/mks_pkg.sv]
// ----------------------------------------------------------------------------
// Keypad scanner package
// Phase encoding, register indexes, field widths and fixed timing constants.
// ----------------------------------------------------------------------------
package mks_pkg;

    // Field widths
    localparam int ROW_LEVELS_W   = 4;
    localparam int COL_DRIVE_W    = 4;
    localparam int KEY_CODE_W     = 5;
    localparam int S_TDATA_W      = 8;
    localparam int M_TDATA_W      = 16;

    // Configuration port
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 10;
    localparam int SETTLE_W       = 8;
    localparam int SAMPLE_W       = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_TICKS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_TICKS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_MODE = 2'd2;

    localparam logic [SETTLE_W-1:0] SETTLE_TICKS_RST = 8'd2;
    localparam logic [SAMPLE_W-1:0] SAMPLE_TICKS_RST = 10'd20;

    // Debounce timing
    localparam int TICK_W = 10;
    localparam logic [TICK_W:0] RELEASE_TICKS = 11'd90;
    localparam int CONFIRM_SAMPLES = 3;
    localparam logic [CONFIRM_SAMPLES-1:0] ALL_HIGH = 3'b111;

    // Only the first four rows can be reported
    localparam int MAX_ROWS = 4;
    localparam int ROW_IDX_W = 2;

    typedef enum logic [2:0] {
        PH_START        = 3'd0,
        PH_SCAN         = 3'd1,
        PH_CONFIRM      = 3'd2,
        PH_WAIT_RELEASE = 3'd3,
        PH_WATCH        = 3'd4
    } phase_t;

endpackage

[src/matrix_keypad_scanner_core.sv]
// ----------------------------------------------------------------------------
// Matrix keypad scanner core
// Column-by-column keypad scan with settle wait, debounce and release detect.
// ----------------------------------------------------------------------------
// Each input item is one timer tick carrying the sampled row levels; each
// tick produces exactly one result item with the column drive after that
// tick, a scan-done mark (m_tlast) and a key code (0 = no key, otherwise
// column + 1 + NUM_COLUMNS * row). The block takes one item per clock cycle
// in steady state while m_tready does not stall results: a tick is captured
// in an input register, the scan state machine updates from it
// combinationally, and the result lands in an output register. The input
// register keeps accepting while a result waits on a stalled m_tready, so
// one more tick is taken before back-pressure reaches s_tready. Configuration
// writes take effect on the next tick; the debounce mode is latched per key capture.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner_core #(
    parameter int NUM_COLUMNS = 4,
    parameter int NUM_ROWS    = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Configuration write port
    input  logic                              cfg_we,
    input  logic [mks_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mks_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    // Tick input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mks_pkg::S_TDATA_W-1:0]     s_tdata,   // [3:0] row_levels

    // Result output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mks_pkg::M_TDATA_W-1:0]     m_tdata,   // [3:0] column_drive, [8:4] key_code
    output logic                              m_tlast    // scan_done
);
    import mks_pkg::*;

    // Column index width and drive vector width (drive is masked to 4 bits)
    localparam int CW    = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
    localparam int DRV_W = (NUM_COLUMNS > COL_DRIVE_W) ? NUM_COLUMNS : COL_DRIVE_W;
    localparam int NR_EFF = (NUM_ROWS < MAX_ROWS) ? NUM_ROWS : MAX_ROWS;
    localparam logic [CW-1:0] LAST_COL = CW'(NUM_COLUMNS - 1);
    localparam int SUM_W = KEY_CODE_W + 1;

    // Configuration registers
    logic [SETTLE_W-1:0] settle_ticks_reg;
    logic [SAMPLE_W-1:0] sample_ticks_reg;
    logic                debounce_mode_reg;

    // Input stage
    logic                    in_valid_reg;
    logic [ROW_LEVELS_W-1:0] in_rows_reg;

    // Scan state
    phase_t                       phase_reg,    phase_next;
    logic [CW-1:0]                scan_col_reg, scan_col_next;
    logic [CW-1:0]                held_col_reg, held_col_next;
    logic [ROW_IDX_W-1:0]         held_row_reg, held_row_next;
    logic [TICK_W-1:0]            tick_reg,     tick_next;
    logic [CONFIRM_SAMPLES-1:0]   sample_reg,   sample_next;
    logic [ROW_IDX_W-1:0]         sidx_reg,     sidx_next;
    logic                         rel_seen_reg, rel_seen_next;

    // Output stage
    logic                   m_valid_reg;
    logic [COL_DRIVE_W-1:0] drive_reg,    drive_next;
    logic                   done_reg,     done_next;
    logic [KEY_CODE_W-1:0]  code_reg,     code_next;

    // Handshake
    logic advance;
    logic s_accept;

    // Datapath helpers
    logic                       row_hit;
    logic [ROW_IDX_W-1:0]       row_idx;
    logic                       held_level;
    logic [TICK_W:0]            tick_inc;
    logic [CONFIRM_SAMPLES-1:0] sample_set;
    logic [SUM_W-1:0]           code_sum;
    logic [KEY_CODE_W-1:0]      held_code;
    logic [DRV_W-1:0]           drive_wide;

    // The input register moves on whenever the output register is free or draining
    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_ticks_reg  <= SETTLE_TICKS_RST;
            sample_ticks_reg  <= SAMPLE_TICKS_RST;
            debounce_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SETTLE_TICKS:  settle_ticks_reg  <= cfg_wdata[SETTLE_W-1:0];
                REG_SAMPLE_TICKS:  sample_ticks_reg  <= cfg_wdata[SAMPLE_W-1:0];
                REG_DEBOUNCE_MODE: debounce_mode_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input stage
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_rows_reg <= s_tdata[ROW_LEVELS_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Row capture: lowest high row among the reportable rows
    // ------------------------------------------------------------------
    always_comb begin
        row_hit = 1'b0;
        row_idx = '0;
        for (int r = NR_EFF - 1; r >= 0; r--) begin
            if (in_rows_reg[r]) begin
                row_hit = 1'b1;
                row_idx = ROW_IDX_W'(r);
            end
        end
    end

    assign held_level = in_rows_reg[held_row_reg];
    assign tick_inc   = {1'b0, tick_reg} + (TICK_W+1)'(1);
    assign code_sum   = SUM_W'(held_col_reg) + SUM_W'(1)
                      + SUM_W'(NUM_COLUMNS) * SUM_W'(held_row_reg);
    assign held_code  = code_sum[KEY_CODE_W-1:0];

    // ------------------------------------------------------------------
    // Scan state machine: next state and result for the tick in the input register
    // ------------------------------------------------------------------
    always_comb begin
        phase_next    = phase_reg;
        scan_col_next = scan_col_reg;
        held_col_next = held_col_reg;
        held_row_next = held_row_reg;
        tick_next     = tick_reg;
        sample_next   = sample_reg;
        sidx_next     = sidx_reg;
        rel_seen_next = rel_seen_reg;
        sample_set    = sample_reg;
        done_next     = 1'b0;
        code_next     = '0;

        unique case (phase_reg)
            PH_SCAN: begin
                if (tick_reg < {{(TICK_W-SETTLE_W){1'b0}}, settle_ticks_reg}) begin
                    tick_next = tick_inc[TICK_W-1:0];
                end else if (row_hit) begin
                    // Key seen: hold this column and start debounce
                    held_row_next = row_idx;
                    held_col_next = scan_col_reg;
                    tick_next     = '0;
                    sample_next   = '0;
                    sidx_next     = '0;
                    rel_seen_next = 1'b0;
                    phase_next    = debounce_mode_reg ? PH_WATCH : PH_CONFIRM;
                end else if (scan_col_reg == LAST_COL) begin
                    // Empty scan
                    done_next  = 1'b1;
                    phase_next = PH_START;
                end else begin
                    scan_col_next = scan_col_reg + CW'(1);
                    tick_next     = '0;
                end
            end
            PH_CONFIRM: begin
                tick_next = tick_inc[TICK_W-1:0];
                // An interval of zero behaves like one
                if (tick_inc >= {1'b0, sample_ticks_reg}) begin
                    tick_next = '0;
                    sample_set[sidx_reg] = held_level;
                    if (sidx_reg == ROW_IDX_W'(CONFIRM_SAMPLES - 1)) begin
                        if (sample_set == ALL_HIGH) begin
                            phase_next = PH_WAIT_RELEASE;
                        end else if (sample_set == '0) begin
                            done_next  = 1'b1;
                            phase_next = PH_START;
                        end
                        // mixed samples: start the triple again
                        sample_next = '0;
                        sidx_next   = '0;
                    end else begin
                        sample_next = sample_set;
                        sidx_next   = sidx_reg + ROW_IDX_W'(1);
                    end
                end
            end
            PH_WAIT_RELEASE: begin
                if (!held_level) begin
                    done_next  = 1'b1;
                    code_next  = held_code;
                    phase_next = PH_START;
                end
            end
            PH_WATCH: begin
                tick_next = tick_inc[TICK_W-1:0];
                if (tick_inc >= RELEASE_TICKS) begin
                    tick_next = '0;
                    if (held_level) begin
                        rel_seen_next = 1'b0;
                    end else if (rel_seen_reg) begin
                        rel_seen_next = 1'b0;
                        done_next     = 1'b1;
                        code_next     = held_code;
                        phase_next    = PH_START;
                    end else begin
                        rel_seen_next = 1'b1;
                    end
                end
            end
            default: begin
                // Scan start: select column 0
                scan_col_next = '0;
                tick_next     = '0;
                phase_next    = PH_SCAN;
            end
        endcase

        // Drive follows the phase after this tick
        drive_wide = '0;
        if (phase_next == PH_SCAN) begin
            drive_wide = DRV_W'(1) << scan_col_next;
        end else if (phase_next == PH_CONFIRM || phase_next == PH_WAIT_RELEASE ||
                     phase_next == PH_WATCH) begin
            drive_wide = DRV_W'(1) << held_col_next;
        end
        drive_next = drive_wide[COL_DRIVE_W-1:0];
    end

    // ------------------------------------------------------------------
    // State and output registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_START;
            scan_col_reg <= '0;
            held_col_reg <= '0;
            held_row_reg <= '0;
            tick_reg     <= '0;
            sample_reg   <= '0;
            sidx_reg     <= '0;
            rel_seen_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (advance) begin
            phase_reg    <= phase_next;
            scan_col_reg <= scan_col_next;
            held_col_reg <= held_col_next;
            held_row_reg <= held_row_next;
            tick_reg     <= tick_next;
            sample_reg   <= sample_next;
            sidx_reg     <= sidx_next;
            rel_seen_reg <= rel_seen_next;
            m_valid_reg  <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg  <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            drive_reg <= drive_next;
            done_reg  <= done_next;
            code_reg  <= code_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = done_reg;
    assign m_tdata  = {{(M_TDATA_W-COL_DRIVE_W-KEY_CODE_W){1'b0}}, code_reg, drive_reg};

endmodule

[src/mks_checker.sv]
// ----------------------------------------------------------------------------
// Keypad scanner port checker
// Watches the result stream and input back-pressure of the scanner core.
// ----------------------------------------------------------------------------
`include "matrix_keypad_scanner_core_macros.svh"

module mks_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [mks_pkg::M_TDATA_W-1:0]     m_tdata,   // [3:0] column_drive, [8:4] key_code
    input logic                              m_tlast    // scan_done
);
    import mks_pkg::*;

    logic [COL_DRIVE_W-1:0] drive;
    logic [KEY_CODE_W-1:0]  code;
    logic [M_TDATA_W:0]     out_word;

    assign drive    = m_tdata[COL_DRIVE_W-1:0];
    assign code     = m_tdata[COL_DRIVE_W+KEY_CODE_W-1:COL_DRIVE_W];
    assign out_word = {m_tlast, m_tdata};

    // A stalled result holds
    `MKS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(out_word), "stalled result changed")

    // At most one column is ever driven
    `MKS_ASSERT_IMPL(a_drive_onehot, m_tvalid, $onehot0(drive), "more than one column driven")

    // A key code only appears on a finished scan
    `MKS_ASSERT_IMPL(a_code_on_done, m_tvalid && !m_tlast, code == '0, "key code without scan done")

    // A finished scan returns to scan start, which drives no column
    `MKS_ASSERT_IMPL(a_done_idle, m_tvalid && m_tlast, drive == '0, "column driven on scan done")

    // The input only stalls behind a waiting result
    `MKS_ASSERT_IMPL(a_stall_cause, !s_tready, m_tvalid && !m_tready, "input stalled with no waiting result")

endmodule

bind matrix_keypad_scanner_core mks_checker u_mks_checker (.*);
